FILE: rtl/paged_bump_allocator_macros.svh
// ----------------------------------------------------------------------------
// paged bump allocator assertion macros
// shared property forms for the allocator checks
// ----------------------------------------------------------------------------
`ifndef PAGED_BUMP_ALLOCATOR_MACROS_SVH
`define PAGED_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PBA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// types and constants shared by the paged bump allocator
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int MAX_PAGES = 16;
	localparam int PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);

	localparam logic [0:0] OP_ALLOC = 1'b0;
	localparam logic [0:0] OP_RESET = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
	localparam logic [1:0] STATUS_NO_PAGE   = 2'd2;

	localparam logic [0:0] REG_PAGE_SIZE     = 1'b0;
	localparam logic [0:0] REG_TRIM_INTERVAL = 1'b1;

	localparam logic [31:0] PAGE_SIZE_RESET     = 32'd2097152;
	localparam logic [15:0] TRIM_INTERVAL_RESET = 16'd64;

	typedef struct packed {
		logic [0:0]  opcode;
		logic [31:0] request_size;
		logic [4:0]  align_log2;
	} pba_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  page_index;
		logic [31:0] byte_offset;
		logic [31:0] granted_size;
		logic [4:0]  pages_in_use;
	} pba_result_t;

endpackage

FILE: rtl/paged_bump_allocator.sv
// ----------------------------------------------------------------------------
// paged_bump_allocator
// a reset request or an oversized allocate gives done straight from the prep state
// an allocate that fits the current page gives done from the current-page check
// otherwise the scan reads one page fill per cycle until a page fits or all are read
// one command at a time; a new start is taken in the cycle done is shown
// arst_n empties all pages and sets the counters and config registers to their reset values
// ----------------------------------------------------------------------------
`include "paged_bump_allocator_macros.svh"

module paged_bump_allocator
	import pba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pba_cmd_t    cmd,
	output logic        done,
	output pba_result_t result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_CUR  = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0]           state_q;
	logic [31:0]          page_size_q;
	logic [15:0]          trim_q;
	logic [CNT_W-1:0]     page_count_q;
	logic [PAGE_W-1:0]    current_q;
	logic [PAGE_W-1:0]    highest_q;
	logic [15:0]          tally_q;
	logic [MAX_PAGES-1:0] fill_vld_q;
	logic                 done_q;
	logic                 chk_vld_s1;

	pba_cmd_t             cmd_q;
	logic [32:0]          granted_q;
	logic [32:0]          amask_q;
	logic [31:0]          limit_q;
	logic [CNT_W-1:0]     scan_addr_q;
	logic [PAGE_W-1:0]    chk_idx_s1;
	logic                 rd_vld_s1;
	pba_result_t          result_q;

	logic                 start_ok;
	logic [32:0]          amask_in;
	logic                 too_large;
	logic                 cur_open;
	logic                 scan_more;
	logic                 pool_full;
	logic [31:0]          ram_rdata;
	logic [31:0]          fill;
	logic [32:0]          off;
	logic                 fit;
	logic [PAGE_W-1:0]    hu_max;
	logic [15:0]          tally_nx;
	logic                 trim_now;
	logic [CNT_W-1:0]     trim_cap;
	logic [CNT_W-1:0]     reset_count;

	logic                 rd_en;
	logic [PAGE_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [PAGE_W-1:0]    wr_addr;
	logic [31:0]          wr_data;

	assign busy      = (state_q != ST_IDLE);
	assign start_ok  = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign amask_in  = (33'd1 << cmd.align_log2) - 33'd1;
	assign too_large = granted_q > {1'b0, page_size_q};
	assign cur_open  = CNT_W'(current_q) < page_count_q;
	assign scan_more = scan_addr_q < page_count_q;
	assign pool_full = page_count_q == CNT_W'(MAX_PAGES);

	// entries never written since the last clear read as empty
	assign fill = rd_vld_s1 ? ram_rdata : 32'd0;
	assign off  = ({1'b0, fill} + amask_q) & ~amask_q;
	assign fit  = off <= {1'b0, limit_q};

	assign hu_max      = (current_q > highest_q) ? current_q : highest_q;
	assign tally_nx    = tally_q + 16'd1;
	assign trim_now    = tally_nx == trim_q;
	assign trim_cap    = CNT_W'(hu_max) + CNT_W'(1);
	assign reset_count = (trim_now && (page_count_q > trim_cap)) ? trim_cap : page_count_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_PREP: begin
				if (cmd_q.opcode == OP_ALLOC && !too_large && cur_open) begin
					rd_en   = 1'b1;
					rd_addr = current_q;
				end
			end
			ST_CUR: begin
				if (fit) begin
					wr_en   = 1'b1;
					wr_addr = current_q;
					wr_data = off[31:0] + granted_q[31:0];
				end
			end
			ST_SCAN: begin
				if (chk_vld_s1 && fit) begin
					wr_en   = 1'b1;
					wr_addr = chk_idx_s1;
					wr_data = off[31:0] + granted_q[31:0];
				end else if (scan_more) begin
					rd_en   = 1'b1;
					rd_addr = scan_addr_q[PAGE_W-1:0];
				end else if (!pool_full) begin
					wr_en   = 1'b1;
					wr_addr = page_count_q[PAGE_W-1:0];
					wr_data = granted_q[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	pba_ram #(
		.WIDTH (32),
		.DEPTH (MAX_PAGES)
	) u_fill_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			page_size_q  <= PAGE_SIZE_RESET;
			trim_q       <= TRIM_INTERVAL_RESET;
			page_count_q <= '0;
			current_q    <= '0;
			highest_q    <= '0;
			tally_q      <= '0;
			fill_vld_q   <= '0;
			done_q       <= 1'b0;
			chk_vld_s1   <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PAGE_SIZE:     page_size_q <= cfg_data;
					REG_TRIM_INTERVAL: trim_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (wr_en) begin
				fill_vld_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_ok) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (cmd_q.opcode == OP_RESET) begin
						fill_vld_q   <= '0;
						page_count_q <= reset_count;
						current_q    <= '0;
						if (trim_now) begin
							tally_q   <= '0;
							highest_q <= '0;
						end else begin
							tally_q   <= tally_nx;
							highest_q <= hu_max;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (too_large) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (cur_open) begin
						state_q <= ST_CUR;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_CUR: begin
					if (fit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chk_vld_s1 && fit) begin
						highest_q <= hu_max;
						current_q <= chk_idx_s1;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (scan_more) begin
						chk_vld_s1 <= 1'b1;
					end else begin
						if (!pool_full) begin
							current_q    <= page_count_q[PAGE_W-1:0];
							page_count_q <= page_count_q + CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command payload, scan pointers and result beat
	always_ff @(posedge clk) begin
		if (start_ok) begin
			cmd_q     <= cmd;
			amask_q   <= amask_in;
			granted_q <= ({1'b0, cmd.request_size} + amask_in) & ~amask_in;
		end
		if (rd_en) begin
			rd_vld_s1  <= fill_vld_q[rd_addr];
			chk_idx_s1 <= rd_addr;
		end
		case (state_q)
			ST_PREP: begin
				limit_q     <= page_size_q - granted_q[31:0];
				scan_addr_q <= '0;
				result_q    <= '0;
				if (cmd_q.opcode == OP_RESET) begin
					result_q.pages_in_use <= 5'(reset_count);
				end else begin
					result_q.status       <= STATUS_TOO_LARGE;
					result_q.pages_in_use <= 5'(page_count_q);
				end
			end
			ST_CUR: begin
				scan_addr_q           <= '0;
				result_q.status       <= STATUS_OK;
				result_q.page_index   <= 4'(current_q);
				result_q.byte_offset  <= off[31:0];
				result_q.granted_size <= granted_q[31:0];
				result_q.pages_in_use <= 5'(page_count_q);
			end
			ST_SCAN: begin
				if (chk_vld_s1 && fit) begin
					result_q.status       <= STATUS_OK;
					result_q.page_index   <= 4'(chk_idx_s1);
					result_q.byte_offset  <= off[31:0];
					result_q.granted_size <= granted_q[31:0];
					result_q.pages_in_use <= 5'(page_count_q);
				end else if (scan_more) begin
					scan_addr_q <= scan_addr_q + CNT_W'(1);
				end else if (pool_full) begin
					result_q              <= '0;
					result_q.status       <= STATUS_NO_PAGE;
					result_q.pages_in_use <= 5'(page_count_q);
				end else begin
					result_q.status       <= STATUS_OK;
					result_q.page_index   <= 4'(page_count_q[PAGE_W-1:0]);
					result_q.byte_offset  <= '0;
					result_q.granted_size <= granted_q[31:0];
					result_q.pages_in_use <= 5'(page_count_q + CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	`PBA_ASSERT_NXT(a_start_busy, start_ok, busy, "accepted command did not raise busy")
	`PBA_ASSERT_NXT(a_done_single, done, !done, "result beat lasted more than one cycle")
	`PBA_ASSERT_IMP(a_count_bound, 1'b1, page_count_q <= CNT_W'(MAX_PAGES), "page count overflow")
	`PBA_ASSERT_IMP(a_err_zero, done && (result.status != STATUS_OK),
		(result.byte_offset == 32'd0) && (result.granted_size == 32'd0),
		"error beat carries an allocation")

endmodule

FILE: rtl/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sim/tb_paged_bump_allocator.sv
// ----------------------------------------------------------------------------
// tb_paged_bump_allocator
// self-checking bench for the paged bump allocator: a clocked driver feeds
// commands from a queue, a predictor computes each grant or error as the
// command is taken, and a monitor matches every done beat against the
// oldest prediction. phases change page size and trim interval while idle.
// ----------------------------------------------------------------------------
module tb_paged_bump_allocator;
	import pba_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 125;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pba_cmd_t    cmd = '0;
	logic        done;
	pba_result_t result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_PAGE_SIZE;
	logic [31:0] cfg_data = '0;

	pba_cmd_t    cmd_q[$];
	pba_result_t grant_q[$];

	logic [31:0] page_used[MAX_PAGES];
	int unsigned open_pages;
	int unsigned active_page;
	int unsigned peak_page;
	logic [15:0] resets_since_trim;
	logic [31:0] cfg_page_size;
	logic [15:0] cfg_trim_every;

	int idle_pct = 30;
	int cycles = 0;
	int n_sent = 0;
	int n_resets = 0;
	int n_ok = 0;
	int n_too_large = 0;
	int n_no_page = 0;
	int n_phases = 0;
	int n_mismatch = 0;

	paged_bump_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
		return (v + a - 64'd1) & ~(a - 64'd1);
	endfunction

	function automatic bit page_has_room(logic [31:0] used, logic [31:0] size,
		logic [63:0] a);
		logic [63:0] tail;
		tail = round_up(round_up({32'd0, used}, a) + {32'd0, size}, a);
		return tail <= {32'd0, cfg_page_size};
	endfunction

	function automatic pba_result_t predict_grant(pba_cmd_t c);
		pba_result_t r;
		logic [63:0] a;
		logic [63:0] granted;
		logic [63:0] off;
		bit found;
		r = '0;
		found = 1'b0;
		a = 64'd1 << c.align_log2;
		if (c.opcode == OP_RESET) begin
			for (int i = 0; i < MAX_PAGES; i++) page_used[i] = '0;
			resets_since_trim = resets_since_trim + 16'd1;
			if (active_page > peak_page) peak_page = active_page;
			if (resets_since_trim == cfg_trim_every) begin
				if (open_pages > peak_page + 1) open_pages = peak_page + 1;
				resets_since_trim = '0;
				peak_page = 0;
			end
			active_page = 0;
			r.pages_in_use = open_pages[4:0];
			return r;
		end
		granted = round_up({32'd0, c.request_size}, a);
		if (granted > {32'd0, cfg_page_size}) begin
			r.status = STATUS_TOO_LARGE;
			r.pages_in_use = open_pages[4:0];
			return r;
		end
		if (active_page < open_pages &&
			page_has_room(page_used[active_page], c.request_size, a)) begin
			found = 1'b1;
		end else begin
			for (int i = 0; i < open_pages; i++) begin
				if (!found && page_has_room(page_used[i], c.request_size, a)) begin
					found = 1'b1;
					if (active_page > peak_page) peak_page = active_page;
					active_page = i;
				end
			end
			if (!found) begin
				if (open_pages >= MAX_PAGES) begin
					r.status = STATUS_NO_PAGE;
					r.pages_in_use = open_pages[4:0];
					return r;
				end
				page_used[open_pages] = '0;
				active_page = open_pages;
				open_pages++;
			end
		end
		off = round_up({32'd0, page_used[active_page]}, a);
		page_used[active_page] = off[31:0] + granted[31:0];
		r.status = STATUS_OK;
		r.page_index = active_page[3:0];
		r.byte_offset = off[31:0];
		r.granted_size = granted[31:0];
		r.pages_in_use = open_pages[4:0];
		return r;
	endfunction

	// command driver: start is held until a beat is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				grant_q = {grant_q, predict_grant(cmd)};
				n_sent++;
				if (cmd.opcode == OP_RESET) n_resets++;
			end
			if (!start || !busy) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cmd <= cmd_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("[%0d] %s: expected %0h, got %0h", cycles, name, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		pba_result_t want;
		if (arst_n && done) begin
			if (grant_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("[%0d] result beat with nothing outstanding", cycles);
			end else begin
				want = grant_q.pop_front();
				case (want.status)
					STATUS_OK:        n_ok++;
					STATUS_TOO_LARGE: n_too_large++;
					default:          n_no_page++;
				endcase
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("page_index", 32'(want.page_index), 32'(result.page_index));
				check_field("byte_offset", want.byte_offset, result.byte_offset);
				check_field("granted_size", want.granted_size, result.granted_size);
				check_field("pages_in_use", 32'(want.pages_in_use),
					32'(result.pages_in_use));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("paged_bump_allocator: mismatch");
		$finish;
	end

	task automatic push_cmd(logic [0:0] op, logic [31:0] size, logic [4:0] lg);
		pba_cmd_t c;
		c.opcode = op;
		c.request_size = size;
		c.align_log2 = lg;
		cmd_q = {cmd_q, c};
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || start || grant_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] psize, logic [15:0] trim);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PAGE_SIZE;
		cfg_data <= psize;
		do @(posedge clk); while (!cfg_ready);
		cfg_page_size = psize;
		cfg_index <= REG_TRIM_INTERVAL;
		cfg_data <= {16'd0, trim};
		do @(posedge clk); while (!cfg_ready);
		cfg_trim_every = trim;
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_phases++;
	endtask

	task automatic gen_random(int n);
		int pick;
		logic [4:0] lg;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			lg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 6));
			if (pick < 9)
				push_cmd(OP_RESET, $urandom, 5'($urandom));
			else if (pick < 20)
				push_cmd(1'($urandom), $urandom, 5'($urandom));
			else if (pick < 35)
				push_cmd(OP_ALLOC, $urandom_range(0, 16), lg);
			else
				push_cmd(OP_ALLOC, $urandom_range(0, cfg_page_size >> 2), lg);
		end
	endtask

	initial begin
		logic [31:0] psize;
		logic [15:0] trim;
		for (int i = 0; i < MAX_PAGES; i++) page_used[i] = '0;
		open_pages = 0;
		active_page = 0;
		peak_page = 0;
		resets_since_trim = '0;
		cfg_page_size = PAGE_SIZE_RESET;
		cfg_trim_every = TRIM_INTERVAL_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset-value registers
		push_cmd(OP_ALLOC, 32'd0, 5'd0);
		push_cmd(OP_ALLOC, 32'hFFFF_FFFF, 5'd0);
		push_cmd(OP_ALLOC, PAGE_SIZE_RESET, 5'd0);
		push_cmd(OP_ALLOC, 32'd1, 5'd31);
		push_cmd(OP_RESET, 32'd0, 5'd0);
		wait_drained();

		// 256-byte pages, trim on every reset
		write_regs(32'd256, 16'd1);
		for (int i = 0; i <= MAX_PAGES; i++) push_cmd(OP_ALLOC, 32'd256, 5'd8);
		push_cmd(OP_ALLOC, 32'd0, 5'd0);
		push_cmd(OP_RESET, 32'd0, 5'd0);
		push_cmd(OP_ALLOC, 32'd200, 5'd0);
		push_cmd(OP_ALLOC, 32'd100, 5'd0);
		push_cmd(OP_ALLOC, 32'd50, 5'd2);
		push_cmd(OP_ALLOC, 32'd1, 5'd8);
		push_cmd(OP_ALLOC, 32'd255, 5'd9);
		push_cmd(OP_ALLOC, 32'd257, 5'd0);
		push_cmd(OP_RESET, 32'd0, 5'd0);
		push_cmd(OP_RESET, 32'd0, 5'd0);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin psize = 32'hFFFF_FFFF; trim = 16'hFFFF; end
				1: begin psize = 32'd256; trim = 16'd1; end
				2: begin psize = $urandom; trim = 16'd0; end
				default: begin
					psize = $urandom_range(256, 4096);
					trim = 16'($urandom_range(1, 6));
				end
			endcase
			write_regs(psize, trim);
			idle_pct = (p == 3) ? 0 : 30;
			gen_random(ITEMS_PER_PHASE);
			wait_drained();
		end

		repeat (24) @(posedge clk);
		$display("sent %0d commands (%0d resets) over %0d register settings",
			n_sent, n_resets, n_phases);
		$display("grants %0d, oversized %0d, out of pages %0d",
			n_ok, n_too_large, n_no_page);
		if (n_mismatch == 0 && grant_q.size() == 0) begin
			$display("paged_bump_allocator: match");
		end else begin
			$display("paged_bump_allocator: mismatch");
		end
		$finish;
	end

endmodule
